>>> rtl/core/button_chord_decoder_defines.svh
// ----------------------------------------------------------------------------
// button_chord_decoder_defines
// Assertion macros for the button chord decoder.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CHORD_DECODER_DEFINES_SVH
`define BUTTON_CHORD_DECODER_DEFINES_SVH

`ifndef SYNTH
`define BCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcd assertion failed");
`define BCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcd assertion failed");
`else
`define BCD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared widths, phase codes and register indexes of the chord decoder.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int PIN_W    = 3;
  localparam int NOW_W    = 32;
  localparam int MASK_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int WINDOW_W = 16;
  localparam int HELD_W   = 4;
  localparam int CYC_W    = 2;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [PHASE_W-1:0]  phase_t;
  typedef logic [MASK_W-1:0]   mask_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [WINDOW_W-1:0] window_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam phase_t PH_IDLE    = 3'd0;
  localparam phase_t PH_WAIT    = 3'd1;
  localparam phase_t PH_CHORD13 = 3'd2;
  localparam phase_t PH_LATCH   = 3'd3;
  localparam phase_t PH_HOLD    = 3'd4;
  localparam phase_t PH_CHORD12 = 3'd5;
  localparam phase_t PH_CHORD23 = 3'd6;

  localparam cfg_idx_t REG_CHORD_WINDOW = 1'd0;
  localparam cfg_idx_t REG_CYCLE_MODE   = 1'd1;

  localparam window_t CHORD_WINDOW_RST = 16'd200;

  localparam logic [HELD_W-1:0] HELD_CHORD13 = 4'd0;
  localparam logic [HELD_W-1:0] HELD_BTN1    = 4'd1;
  localparam logic [HELD_W-1:0] HELD_BTN2    = 4'd2;
  localparam logic [HELD_W-1:0] HELD_BTN3    = 4'd3;
  localparam logic [HELD_W-1:0] HELD_CHORD12 = 4'd4;
  localparam logic [HELD_W-1:0] HELD_CHORD23 = 4'd5;
  localparam logic [HELD_W-1:0] HELD_CYC0    = 4'd6;

endpackage

>>> rtl/core/button_chord_decoder.sv
// ----------------------------------------------------------------------------
// button_chord_decoder
// Turns active-low button samples into chorded logical buttons and HID bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pin sample (pin_levels, now_ms), valid/ready.
//   out_* : one beat per sample: logical mask and report bytes 0, 1, 3.
//   cfg_* : write port; index 0 is the chord window in ms, index 1 the
//           cycle-mode flag. Write only while no beat is in flight.
// The phase update and the report packing are combinational and sit
// between the input port and the output register. Throughput is one
// beat per cycle; in_ready stays high while the output register is
// empty or being drained in the same cycle.
// When the receiver stalls, the output beat is held and in_ready drops
// until it is taken; no sample is lost or repeated.
// Reset (rst_n low, synchronous) returns the phase to idle, clears the
// press time, held button and cycle index, sets the window to 200 ms,
// clears cycle mode and empties the output register.
// ----------------------------------------------------------------------------
`include "button_chord_decoder_defines.svh"

module button_chord_decoder #(
  parameter int TIME_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  bcd_pkg::cfg_idx_t       cfg_index,
  input  bcd_pkg::window_t        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_pin_levels,
  input  logic [31:0]             in_now_ms,
  output logic                    out_valid,
  input  logic                    out_ready,
  output bcd_pkg::mask_t          out_button_mask,
  output bcd_pkg::byte_t          out_report_byte0,
  output bcd_pkg::byte_t          out_report_byte1,
  output bcd_pkg::byte_t          out_report_byte3
);
  import bcd_pkg::*;

  typedef logic [TIME_WIDTH-1:0] time_t;

  window_t             window_r;
  logic                cycle_mode_r;
  phase_t              phase_r, phase_nxt;
  time_t               press_time_r, press_time_nxt;
  logic [HELD_W-1:0]   held_r, held_nxt;
  logic [CYC_W-1:0]    cyc_r, cyc_nxt;

  logic                out_valid_r;
  mask_t               mask_r, mask_nxt;
  byte_t               b0_r, b0_nxt, b1_r, b1_nxt, b3_r, b3_nxt;

  logic                in_accept;
  logic [PIN_W-1:0]    pins;
  logic [MASK_W-1:0]   raw_m;
  time_t               now_t, elapsed;
  logic                timed_out;
  logic [HELD_W-1:0]   cyc_held;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  assign pins      = ~in_pin_levels;
  assign raw_m     = {5'b0, pins, 1'b0};
  assign now_t     = TIME_WIDTH'(in_now_ms);
  assign elapsed   = now_t - press_time_r;
  assign timed_out = elapsed > TIME_WIDTH'(window_r);
  assign cyc_held  = HELD_CYC0 + HELD_W'(cyc_r);

  always_comb begin
    phase_nxt      = phase_r;
    press_time_nxt = press_time_r;
    held_nxt       = held_r;
    cyc_nxt        = cyc_r;
    mask_nxt       = raw_m;
    unique case (phase_r)
      PH_IDLE: begin
        if (pins != '0) begin
          phase_nxt      = PH_WAIT;
          press_time_nxt = now_t;
          mask_nxt       = '0;
        end
      end
      PH_WAIT: begin
        priority if (timed_out) begin
          phase_nxt = PH_LATCH;
        end else if (pins[0] && pins[2]) begin
          phase_nxt = PH_CHORD13;
        end else if (pins[0] && pins[1]) begin
          phase_nxt = PH_CHORD12;
        end else if (pins[1] && pins[2]) begin
          phase_nxt = PH_CHORD23;
        end else begin
          phase_nxt = PH_WAIT;
        end
        mask_nxt = '0;
      end
      PH_CHORD13: begin
        mask_nxt  = (raw_m & 9'h004) | 9'h001;
        phase_nxt = PH_HOLD;
        held_nxt  = HELD_CHORD13;
      end
      PH_LATCH: begin
        phase_nxt = PH_HOLD;
        priority if (pins[0]) begin
          held_nxt = HELD_BTN1;
        end else if (pins[1]) begin
          if (cycle_mode_r) begin
            if (cyc_held < HELD_W'(MASK_W)) begin
              mask_nxt = raw_m | (mask_t'(1) << cyc_held);
            end
            held_nxt = cyc_held;
            unique case (cyc_r)
              2'd0:    cyc_nxt = 2'd1;
              2'd1:    cyc_nxt = 2'd2;
              2'd2:    cyc_nxt = 2'd0;
              default: cyc_nxt = 2'd1;
            endcase
          end else begin
            held_nxt = HELD_BTN2;
          end
        end else begin
          held_nxt = HELD_BTN3;
        end
      end
      PH_HOLD: begin
        if (pins == '0) begin
          phase_nxt = PH_IDLE;
        end
        mask_nxt = (held_r < HELD_W'(MASK_W)) ? (mask_t'(1) << held_r) : '0;
      end
      PH_CHORD12: begin
        mask_nxt  = 9'h010;
        phase_nxt = PH_HOLD;
        held_nxt  = HELD_CHORD12;
      end
      PH_CHORD23: begin
        mask_nxt  = 9'h020;
        phase_nxt = PH_HOLD;
        held_nxt  = HELD_CHORD23;
      end
      default: begin
      end
    endcase
  end

  // report packing
  always_comb begin
    if (cycle_mode_r) begin
      b0_nxt = {2'b0, mask_nxt[6], mask_nxt[7], 1'b0, mask_nxt[8], mask_nxt[1], mask_nxt[0]};
      b1_nxt = {3'b0, mask_nxt[5], 3'b0, mask_nxt[4]};
      b3_nxt = {5'b0, mask_nxt[3], 2'b0};
    end else begin
      b0_nxt = {2'b0, mask_nxt[3], mask_nxt[2], 1'b0, mask_nxt[1], mask_nxt[5], mask_nxt[0]};
      b1_nxt = '0;
      b3_nxt = {5'b0, mask_nxt[4], 2'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= CHORD_WINDOW_RST;
      cycle_mode_r <= 1'b0;
      phase_r      <= PH_IDLE;
      press_time_r <= '0;
      held_r       <= '0;
      cyc_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CHORD_WINDOW: window_r     <= cfg_data;
          REG_CYCLE_MODE:   cycle_mode_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase_r      <= phase_nxt;
        press_time_r <= press_time_nxt;
        held_r       <= held_nxt;
        cyc_r        <= cyc_nxt;
      end
      out_valid_r <= in_accept || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mask_r <= mask_nxt;
      b0_r   <= b0_nxt;
      b1_r   <= b1_nxt;
      b3_r   <= b3_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_button_mask  = mask_r;
  assign out_report_byte0 = b0_r;
  assign out_report_byte1 = b1_r;
  assign out_report_byte3 = b3_r;

  `BCD_ASSERT_NEXT(a_press_starts_wait, clk, rst_n, in_accept && phase_r == PH_IDLE && in_pin_levels != 3'b111, phase_r == PH_WAIT)
  `BCD_ASSERT_NEXT(a_release_ends_hold, clk, rst_n, in_accept && phase_r == PH_HOLD && in_pin_levels == 3'b111, phase_r == PH_IDLE)
  `BCD_ASSERT_NOW(a_cycle_index_range, clk, rst_n, 1'b1, cyc_r != 2'd3)
  `BCD_ASSERT_NOW(a_mask_bits_bounded, clk, rst_n, out_valid_r, $countones(mask_r) <= 4)

endmodule

>>> dv/button_chord_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_decoder_tb
// Self-checking bench for the chord decoder. A directed table walks chords,
// timeouts, window edges and timestamp wrap. Random press/chord/hold/release
// gestures follow, under several window and cycle-mode settings. Every report
// beat is compared with an in-bench decoder model. Both sides take random
// stalls.
// ----------------------------------------------------------------------------
module button_chord_decoder_tb;
  import bcd_pkg::*;

  localparam int N_ITEMS   = 1150;
  localparam int N_SETS    = 7;
  localparam int WDOG_MAX  = 2000;
  localparam int LONG_HOLD = 80;
  localparam int DIR_N     = 26;

  typedef struct packed {
    mask_t mask;
    byte_t b0;
    byte_t b1;
    byte_t b3;
  } report_t;

  typedef struct packed {
    logic [2:0]  pins;
    logic [31:0] now;
    logic        typed;
    report_t     want;
  } dir_row_t;

  localparam report_t NO_REPORT = '0;
  localparam report_t CHORD12_N = '{9'h010, 8'h00, 8'h00, 8'h04};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  window_t     cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_pin_levels;
  logic [31:0] in_now_ms;
  logic        out_valid;
  logic        out_ready;
  mask_t       out_button_mask;
  byte_t       out_report_byte0;
  byte_t       out_report_byte1;
  byte_t       out_report_byte3;

  // decoder model state
  phase_t      dec_phase;
  logic [31:0] dec_press_time;
  logic [3:0]  dec_held;
  logic [1:0]  dec_cyc;
  window_t     dec_window;
  logic        dec_cycle_mode;

  report_t     pending_reports[$];
  int          n_sent;
  int          n_checked;
  int          n_err;
  int          quiet_cycles;
  bit          idle_on;
  bit          hold_long;
  logic [31:0] now_cur;

  dir_row_t dir_rows [DIR_N] = '{
    '{3'b111, 32'd0,          1'b1, NO_REPORT},
    '{3'b000, 32'd5,          1'b1, NO_REPORT},
    '{3'b000, 32'd205,        1'b1, NO_REPORT}, // exactly at window edge
    '{3'b000, 32'd206,        1'b0, NO_REPORT}, // chord 1+3, raw btn2 kept
    '{3'b111, 32'd207,        1'b0, NO_REPORT},
    '{3'b110, 32'd1000,       1'b0, NO_REPORT},
    '{3'b110, 32'd1201,       1'b0, NO_REPORT}, // one past window
    '{3'b110, 32'd1202,       1'b0, NO_REPORT},
    '{3'b110, 32'd1203,       1'b0, NO_REPORT},
    '{3'b111, 32'd1204,       1'b0, NO_REPORT},
    '{3'b101, 32'hFFFF_FFF0,  1'b0, NO_REPORT},
    '{3'b100, 32'h0000_0010,  1'b0, NO_REPORT}, // chord 1+2 across wrap
    '{3'b100, 32'h0000_0020,  1'b1, CHORD12_N},
    '{3'b111, 32'h0000_0030,  1'b1, CHORD12_N},
    '{3'b001, 32'd100,        1'b0, NO_REPORT},
    '{3'b001, 32'd110,        1'b0, NO_REPORT},
    '{3'b001, 32'd120,        1'b0, NO_REPORT},
    '{3'b111, 32'd130,        1'b0, NO_REPORT},
    '{3'b011, 32'd0,          1'b0, NO_REPORT},
    '{3'b011, 32'hFFFF_FFFF,  1'b0, NO_REPORT}, // largest elapsed time
    '{3'b011, 32'd1,          1'b0, NO_REPORT},
    '{3'b111, 32'd2,          1'b0, NO_REPORT},
    '{3'b101, 32'd10,         1'b0, NO_REPORT},
    '{3'b101, 32'd500,        1'b0, NO_REPORT},
    '{3'b101, 32'd501,        1'b0, NO_REPORT},
    '{3'b111, 32'd502,        1'b0, NO_REPORT}
  };

  button_chord_decoder u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_levels    (in_pin_levels),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button_mask  (out_button_mask),
    .out_report_byte0 (out_report_byte0),
    .out_report_byte1 (out_report_byte1),
    .out_report_byte3 (out_report_byte3)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mask_t logical_bit(input logic [3:0] idx);
    return (idx < 4'd9) ? (mask_t'(1) << idx) : '0;
  endfunction

  function automatic report_t decode_sample(input logic [2:0] pin_levels,
                                            input logic [31:0] now);
    logic [2:0]  pressed;
    logic [31:0] elapsed;
    mask_t       m;
    report_t     r;
    pressed = ~pin_levels;
    elapsed = now - dec_press_time;
    m = {5'b0, pressed, 1'b0};
    case (dec_phase)
      PH_IDLE: begin
        if (pressed != 3'b000) begin
          dec_phase      = PH_WAIT;
          dec_press_time = now;
          m              = '0;
        end
      end
      PH_WAIT: begin
        if (elapsed > {16'b0, dec_window}) dec_phase = PH_LATCH;
        else if (pressed[0] && pressed[2]) dec_phase = PH_CHORD13;
        else if (pressed[0] && pressed[1]) dec_phase = PH_CHORD12;
        else if (pressed[1] && pressed[2]) dec_phase = PH_CHORD23;
        m = '0;
      end
      PH_CHORD13: begin
        m         = (m & 9'h004) | 9'h001;
        dec_phase = PH_HOLD;
        dec_held  = HELD_CHORD13;
      end
      PH_LATCH: begin
        dec_phase = PH_HOLD;
        if (pressed[0]) begin
          dec_held = HELD_BTN1;
        end else if (pressed[1]) begin
          if (dec_cycle_mode) begin
            m        = m | logical_bit(HELD_CYC0 + dec_cyc);
            dec_held = HELD_CYC0 + dec_cyc;
            dec_cyc  = 2'((dec_cyc + 3'd1) % 3'd3);
          end else begin
            dec_held = HELD_BTN2;
          end
        end else begin
          dec_held = HELD_BTN3;
        end
      end
      PH_HOLD: begin
        if (pressed == 3'b000) dec_phase = PH_IDLE;
        m = logical_bit(dec_held);
      end
      PH_CHORD12: begin
        m         = 9'h010;
        dec_phase = PH_HOLD;
        dec_held  = HELD_CHORD12;
      end
      PH_CHORD23: begin
        m         = 9'h020;
        dec_phase = PH_HOLD;
        dec_held  = HELD_CHORD23;
      end
      default: ;
    endcase
    r.mask = m;
    if (dec_cycle_mode) begin
      r.b0 = {2'b0, m[6], m[7], 1'b0, m[8], m[1], m[0]};
      r.b1 = {3'b0, m[5], 3'b0, m[4]};
      r.b3 = {5'b0, m[3], 2'b0};
    end else begin
      r.b0 = {2'b0, m[3], m[2], 1'b0, m[1], m[5], m[0]};
      r.b1 = 8'h00;
      r.b3 = {5'b0, m[4], 2'b0};
    end
    return r;
  endfunction

  // one input beat; valid stays up afterwards until the next call or a drain
  task automatic send_sample(input logic [2:0] p, input logic [31:0] t);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= p;
    in_now_ms     <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(decode_sample(p, t));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input window_t w, input logic cm);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHORD_WINDOW;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_CYCLE_MODE;
    cfg_data  <= window_t'(cm);
    @(posedge clk);
    cfg_we         <= 1'b0;
    dec_window     = w;
    dec_cycle_mode = cm;
    @(posedge clk);
  endtask

  function automatic logic [2:0] one_button();
    case ($urandom_range(0, 2))
      0:       return 3'b110;
      1:       return 3'b101;
      default: return 3'b011;
    endcase
  endfunction

  function automatic logic [2:0] chord_pins();
    case ($urandom_range(0, 3))
      0:       return 3'b010;
      1:       return 3'b100;
      2:       return 3'b001;
      default: return 3'b000;
    endcase
  endfunction

  // press, then a chord, a timeout or junk, then hold and release
  task automatic play_gesture();
    logic [2:0]  first_pins;
    logic [31:0] t0;
    int          kind;
    if ($urandom_range(0, 19) == 0) now_cur = 32'hFFFF_FF00 + $urandom_range(0, 255);
    repeat ($urandom_range(0, 2)) begin
      now_cur += $urandom_range(1, 40);
      send_sample(3'b111, now_cur);
    end
    first_pins = one_button();
    t0         = now_cur + $urandom_range(1, 40);
    now_cur    = t0;
    send_sample(first_pins, t0);
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      if ($urandom_range(0, 2) == 0) send_sample(first_pins, t0 + $urandom_range(0, dec_window));
      now_cur = t0 + $urandom_range(0, dec_window);
      send_sample(chord_pins(), now_cur);
    end else if (kind < 9) begin
      now_cur = t0 + dec_window + 32'd1 + $urandom_range(0, 30);
      send_sample(first_pins, now_cur);
    end else begin
      now_cur = $urandom();
      send_sample(3'($urandom_range(0, 7)), now_cur);
    end
    now_cur += $urandom_range(0, 40);
    send_sample(3'($urandom_range(0, 6)), now_cur);
    repeat ($urandom_range(0, 3)) begin
      now_cur += $urandom_range(0, 40);
      send_sample(3'($urandom_range(0, 7)), now_cur);
    end
    now_cur += $urandom_range(1, 40);
    send_sample(3'b111, now_cur);
  endtask

  // report checker
  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected report beat: mask %h", out_button_mask);
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        if (out_button_mask !== want.mask || out_report_byte0 !== want.b0 ||
            out_report_byte1 !== want.b1 || out_report_byte3 !== want.b3) begin
          n_err++;
          if (n_err <= 10)
            $display("beat %0d: exp mask %h b0 %h b1 %h b3 %h, got mask %h b0 %h b1 %h b3 %h",
                     n_checked, want.mask, want.b0, want.b1, want.b3, out_button_mask,
                     out_report_byte0, out_report_byte1, out_report_byte3);
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
        hold_long = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog: no beat moved for %0d cycles", WDOG_MAX);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main
    window_t set_window [N_SETS];
    logic    set_cycle  [N_SETS];
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_CHORD_WINDOW;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_pin_levels  = 3'b111;
    in_now_ms      = '0;
    dec_phase      = PH_IDLE;
    dec_press_time = '0;
    dec_held       = '0;
    dec_cyc        = '0;
    dec_window     = CHORD_WINDOW_RST;
    dec_cycle_mode = 1'b0;
    n_sent         = 0;
    n_checked      = 0;
    n_err          = 0;
    quiet_cycles   = 0;
    idle_on        = 1'b1;
    hold_long      = 1'b0;
    now_cur        = $urandom();
    set_window = '{CHORD_WINDOW_RST, 16'd0, 16'hFFFF, 16'hFFFF,
                   window_t'($urandom_range(1, 1000)), window_t'($urandom_range(1, 1000)),
                   16'd37};
    set_cycle  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_sample(dir_rows[i].pins, dir_rows[i].now);
      if (dir_rows[i].typed) pending_reports[$] = dir_rows[i].want;
    end

    for (int s = 0; s < N_SETS; s++) begin
      if (s > 0) begin
        drain();
        write_config(set_window[s], set_cycle[s]);
      end
      if (s == 4) hold_long = 1'b1;
      if (s == N_SETS - 1) idle_on = 1'b0;
      while (n_sent < (s + 1) * N_ITEMS / N_SETS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) send_sample(3'($urandom_range(0, 7)), $urandom());
        end else begin
          play_gesture();
        end
      end
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Drove %0d pin samples and checked %0d reports over %0d settings", n_sent,
             n_checked, N_SETS);
    $display("(chord window 0 to 65535 ms, cycle mode off and on, timestamp wrap)");
    if (n_err == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
